### rtl/core/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types, constants and arithmetic helpers for the Bezier flattener.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int COORD_W     = 24;
  localparam int MAX_DEPTH   = 6;
  localparam int LEVEL_W     = 3;
  localparam int LIMIT_W     = 52;
  localparam int DIFF_W      = 26;   // magnitude of 3*c - 2*n - f
  localparam int SQ_W        = 2 * DIFF_W;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(59048);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } curve_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   capped;
    logic   last;
  } point_t;

  typedef struct packed {
    logic               busy;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] depth;
  } status_t;

  // Midpoint, rounding towards minus infinity
  function automatic coord_t half_floor(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] s;
    s = (COORD_W+1)'(a) + (COORD_W+1)'(b);
    return s[COORD_W:1];
  endfunction

  // |3*c - 2*n - f|
  function automatic logic [DIFF_W-1:0] diff_mag(input coord_t c, input coord_t n,
                                                 input coord_t f);
    logic signed [DIFF_W:0] cw, nw, fw, d;
    cw = (DIFF_W+1)'(c);
    nw = (DIFF_W+1)'(n);
    fw = (DIFF_W+1)'(f);
    d  = (cw <<< 1) + cw - (nw <<< 1) - fw;
    return d[DIFF_W] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

### rtl/core/cbf_curve_queue.sv
// ----------------------------------------------------------------------------
// cbf_curve_queue
// Two-word queue of curves between the input port and the subdivision engine.
// ----------------------------------------------------------------------------
module cbf_curve_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  cbf_pkg::curve_t wr_data,
  output logic            full,
  input  logic            rd,
  output logic            valid,
  output cbf_pkg::curve_t rd_data
);
  import cbf_pkg::*;

  curve_t     mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        wp <= ~wp;
      end
      if (rd && valid) begin
        rp <= ~rp;
      end
      count <= count + 2'(wr && !full) - 2'(rd && valid);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

### rtl/core/cbf_point_queue.sv
// ----------------------------------------------------------------------------
// cbf_point_queue
// Two-word result queue between the engine and the output port.
// ----------------------------------------------------------------------------
module cbf_point_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  cbf_pkg::point_t wr_data,
  output logic            full,
  input  logic            rd,
  output logic            empty,
  output cbf_pkg::point_t rd_data
);
  import cbf_pkg::*;

  point_t     mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        wp <= ~wp;
      end
      if (rd && !empty) begin
        rp <= ~rp;
      end
      count <= count + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

### rtl/core/cbf_subdiv.sv
// ----------------------------------------------------------------------------
// cbf_subdiv
// Subdivision engine: flatness test, de Casteljau split, stack of halves.
// ----------------------------------------------------------------------------
module cbf_subdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cbf_pkg::LIMIT_W-1:0]  limit,
  input  logic                         in_valid,
  input  cbf_pkg::curve_t              in_curve,
  output logic                         in_take,
  input  logic                         out_full,
  output logic                         out_wr,
  output cbf_pkg::point_t              out_point,
  output cbf_pkg::status_t             status
);
  import cbf_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIFF   = 2'd1;
  localparam logic [1:0] S_SQR    = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0]          state;
  curve_t              cur;
  logic [LEVEL_W-1:0]  depth, level;
  logic [DIFF_W-1:0]   dm [4];
  logic [SQ_W-1:0]     sq [4];
  curve_t              stk_curve [MAX_DEPTH];
  logic [LEVEL_W-1:0]  stk_depth [MAX_DEPTH];

  logic [SQ_W-1:0]     max_x, max_y;
  logic [SQ_W:0]       flat_sum;
  logic                flat, leaf;
  curve_t              half_a, half_b;
  coord_t              qx1, qx2, qx3, rx1, rx2, px, qy1, qy2, qy3, ry1, ry2, py;

  always_comb begin
    max_x    = (sq[0] < sq[2]) ? sq[2] : sq[0];
    max_y    = (sq[1] < sq[3]) ? sq[3] : sq[1];
    flat_sum = {1'b0, max_x} + {1'b0, max_y};
    flat     = flat_sum < (SQ_W+1)'(limit);
    leaf     = flat || (depth == LEVEL_W'(MAX_DEPTH));

    qx1 = half_floor(cur.x[0], cur.x[1]);
    qx2 = half_floor(cur.x[1], cur.x[2]);
    qx3 = half_floor(cur.x[2], cur.x[3]);
    rx1 = half_floor(qx1, qx2);
    rx2 = half_floor(qx2, qx3);
    px  = half_floor(rx1, rx2);
    qy1 = half_floor(cur.y[0], cur.y[1]);
    qy2 = half_floor(cur.y[1], cur.y[2]);
    qy3 = half_floor(cur.y[2], cur.y[3]);
    ry1 = half_floor(qy1, qy2);
    ry2 = half_floor(qy2, qy3);
    py  = half_floor(ry1, ry2);
    half_a.x = {px, rx1, qx1, cur.x[0]};
    half_a.y = {py, ry1, qy1, cur.y[0]};
    half_b.x = {cur.x[3], qx3, rx2, px};
    half_b.y = {cur.y[3], qy3, ry2, py};
  end

  assign in_take          = (state == S_IDLE) && in_valid;
  assign out_wr           = (state == S_DECIDE) && leaf && !out_full;
  assign out_point.x      = cur.x[3];
  assign out_point.y      = cur.y[3];
  assign out_point.capped = !flat;
  assign out_point.last   = (level == '0);
  assign status.busy      = (state != S_IDLE);
  assign status.level     = level;
  assign status.depth     = depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      level <= '0;
      depth <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            level <= '0;
            depth <= '0;
            state <= S_DIFF;
          end
        end
        S_DIFF:  state <= S_SQR;
        S_SQR:   state <= S_DECIDE;
        S_DECIDE: begin
          if (leaf) begin
            if (!out_full) begin
              if (level == '0) begin
                state <= S_IDLE;
              end else begin
                level <= level - 1'b1;
                depth <= stk_depth[level - 1'b1];
                state <= S_DIFF;
              end
            end
          end else begin
            level <= level + 1'b1;
            depth <= depth + 1'b1;
            state <= S_DIFF;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: curve, stack and pipeline registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur <= in_curve;
    end else if (state == S_DECIDE) begin
      if (!leaf) begin
        cur <= half_a;
        stk_curve[level] <= half_b;
        stk_depth[level] <= depth + 1'b1;
      end else if (!out_full && level != '0) begin
        cur <= stk_curve[level - 1'b1];
      end
    end
    if (state == S_DIFF) begin
      dm[0] <= diff_mag(cur.x[1], cur.x[0], cur.x[3]);
      dm[1] <= diff_mag(cur.y[1], cur.y[0], cur.y[3]);
      dm[2] <= diff_mag(cur.x[2], cur.x[3], cur.x[0]);
      dm[3] <= diff_mag(cur.y[2], cur.y[3], cur.y[0]);
    end
    if (state == S_SQR) begin
      for (int i = 0; i < 4; i++) begin
        sq[i] <= dm[i] * dm[i];
      end
    end
  end

endmodule

### rtl/core/cubic_bezier_flattener_unit.sv
// Each piece tested passes through the difference, square and decide stages; a
//   curve split into L leaves is tested as 2L-1 pieces, and the engine returns
//   to idle before the next curve is taken, so it cannot take a new curve before
//   it is through with the last one; output stalls hold it in the decide stage.
// Two-word queues on each side let input and output stall independently.
// Reset (rst, synchronous, active high) empties both queues, idles the engine
//   and loads the flatness limit with its default of 59048.
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_unit
// Flattens cubic Bezier curves into polyline end points by adaptive halving.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_unit (
  input  logic                        clk,
  input  logic                        rst,
  // curve input queue
  input  logic                        push,
  output logic                        full,
  input  cbf_pkg::coord_t             start_x,
  input  cbf_pkg::coord_t             start_y,
  input  cbf_pkg::coord_t             ctrl_a_x,
  input  cbf_pkg::coord_t             ctrl_a_y,
  input  cbf_pkg::coord_t             ctrl_b_x,
  input  cbf_pkg::coord_t             ctrl_b_y,
  input  cbf_pkg::coord_t             end_x,
  input  cbf_pkg::coord_t             end_y,
  // point output queue
  output logic                        empty,
  input  logic                        pop,
  output cbf_pkg::coord_t             point_x,
  output cbf_pkg::coord_t             point_y,
  output logic                        depth_capped,
  output logic                        last_point,
  // flatness limit write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cbf_pkg::LIMIT_W-1:0] flatness_limit
);
  import cbf_pkg::*;

  logic [LIMIT_W-1:0] limit;
  curve_t             in_word, q_curve;
  logic               q_valid, q_take;
  logic               pt_wr, pt_full;
  point_t             pt_word, out_word;
  status_t            status;

  // Pack the input word: x and y lists in path order
  assign in_word.x = {end_x, ctrl_b_x, ctrl_a_x, start_x};
  assign in_word.y = {end_y, ctrl_b_y, ctrl_a_y, start_y};

  // Limit register: writes are only expected while idle, so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= flatness_limit;
    end
  end

  // Front: hold incoming curves until the engine is free
  cbf_curve_queue u_front (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (in_word),
    .full    (full),
    .rd      (q_take),
    .valid   (q_valid),
    .rd_data (q_curve)
  );

  // Back: test, split and stack pieces; emit leaf end points in path order
  cbf_subdiv u_engine (
    .clk       (clk),
    .rst       (rst),
    .limit     (limit),
    .in_valid  (q_valid),
    .in_curve  (q_curve),
    .in_take   (q_take),
    .out_full  (pt_full),
    .out_wr    (pt_wr),
    .out_point (pt_word),
    .status    (status)
  );

  // Result queue: decouple the engine from a stalled consumer
  cbf_point_queue u_results (
    .clk     (clk),
    .rst     (rst),
    .wr      (pt_wr),
    .wr_data (pt_word),
    .full    (pt_full),
    .rd      (pop),
    .empty   (empty),
    .rd_data (out_word)
  );

  assign point_x      = out_word.x;
  assign point_y      = out_word.y;
  assign depth_capped = out_word.capped;
  assign last_point   = out_word.last;

`ifndef SYNTHESIS
  // Stack never grows past the depth limit
  a_level_bound : assert property (@(posedge clk) disable iff (rst)
    status.level <= LEVEL_W'(MAX_DEPTH))
    else $error("stack level beyond depth limit");

  // Pending halves never outnumber the split depth
  a_level_depth : assert property (@(posedge clk) disable iff (rst)
    status.busy |-> status.level <= status.depth)
    else $error("stack level exceeds piece depth");

  // Engine drops to idle only after writing a final point
  a_idle_after_last : assert property (@(posedge clk) disable iff (rst)
    $fell(status.busy) |-> $past(pt_wr) && $past(pt_word.last))
    else $error("engine idled without a final point");
`endif

endmodule
